// ===== rtl/cfb_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the CRC-16 frame builder.
// No dependencies.
package cfb_pkg;

   localparam int ID_W   = 16;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] SYNC1_BYTE  = 8'hA5;
   localparam logic [BYTE_W-1:0] SYNC2_BYTE  = 8'h5A;
   localparam logic [BYTE_W-1:0] END_BYTE    = 8'hAA;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd247;
   localparam logic [BYTE_W-1:0] LEN_OFFSET  = 8'd8;
   localparam logic [ID_W-1:0]   CRC_POLY    = 16'h1021;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One command from front to back: the bytes that a single item causes.
   typedef struct packed {
      logic              is_open;   // item opens a frame: emit header first
      logic              has_data;  // item carries a payload byte
      logic              trailer;   // item closes the frame: emit CRC and end byte
      logic [BYTE_W-1:0] len_byte;  // payload count plus 8
      logic [ID_W-1:0]   id;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   function automatic logic [ID_W-1:0] crc16_byte(input logic [ID_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [ID_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[ID_W-1]) begin
            c = {c[ID_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[ID_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/cfb_if.sv =====
// Valid/ready channel interfaces for payload items and framed output bytes.
// Depends on cfb_pkg.
interface cfb_req_if import cfb_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   frame_id;
   logic [BYTE_W-1:0] payload_length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output frame_id, output payload_length,
                   output data_byte, input ready);
   modport sink   (input valid, input frame_id, input payload_length,
                   input data_byte, output ready);
endinterface

interface cfb_rsp_if import cfb_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              frame_end;
   logic              run_last;

   modport source (output valid, output out_byte, output frame_end,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input frame_end,
                   input run_last, output ready);
endinterface

// ===== rtl/cfb_front.sv =====
// Front end: accepts items, tracks frame position and issues one command per item.
// Depends on cfb_pkg.
module cfb_front import cfb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [ID_W-1:0]   in_id,
   input  logic [BYTE_W-1:0] in_len,
   input  logic [BYTE_W-1:0] in_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cmd_type           cmd
);

   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0] len_sat;
   logic [BYTE_W-1:0] left_mid;
   logic              accept;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign accept    = in_valid && cmd_ready;

   assign len_sat  = (in_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_len;
   assign left_mid = bytes_left_ff - 1'b1;

   always_comb begin
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      cmd.id        = in_id;
      cmd.data      = in_data;
      cmd.len_byte  = len_sat + LEN_OFFSET;
      if (!in_frame_ff) begin
         cmd.is_open  = 1'b1;
         cmd.has_data = (len_sat != '0);
         cmd.trailer  = (len_sat <= 8'd1);
         if (accept) begin
            in_frame_in   = (len_sat > 8'd1);
            bytes_left_in = (len_sat == '0) ? '0 : len_sat - 1'b1;
         end
      end else begin
         cmd.is_open  = 1'b0;
         cmd.has_data = 1'b1;
         cmd.trailer  = (left_mid == '0);
         if (accept) begin
            in_frame_in   = (left_mid != '0);
            bytes_left_in = left_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ===== rtl/cfb_queue.sv =====
// Small command queue between the front end and the byte sequencer.
// Depends on cfb_pkg.
module cfb_queue import cfb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/cfb_back.sv =====
// Back end: steps through the frame bytes of each command, runs the CRC and
// drives the registered output item. Depends on cfb_pkg.
module cfb_back import cfb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  cmd_type           cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_end,
   output logic              out_last
);

   localparam logic [3:0] STEP_SYNC1 = 4'd0;
   localparam logic [3:0] STEP_SYNC2 = 4'd1;
   localparam logic [3:0] STEP_LEN   = 4'd2;
   localparam logic [3:0] STEP_IDHI  = 4'd3;
   localparam logic [3:0] STEP_IDLO  = 4'd4;
   localparam logic [3:0] STEP_DATA  = 4'd5;
   localparam logic [3:0] STEP_CRCL  = 4'd6;
   localparam logic [3:0] STEP_CRCH  = 4'd7;
   localparam logic [3:0] STEP_END   = 4'd8;

   logic [3:0]        step_ff, step_in;
   logic              started_ff, started_in;
   logic [ID_W-1:0]   crc_ff, crc_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              end_ff, last_ff;

   logic [3:0]        cur;
   logic [3:0]        nxt;
   logic [BYTE_W-1:0] cur_byte;
   logic              cur_last;
   logic              emit;

   assign cur  = started_ff ? step_ff : (cmd.is_open ? STEP_SYNC1 : STEP_DATA);
   assign emit = cmd_valid && (!valid_ff || out_ready);

   always_comb begin
      cur_byte = END_BYTE;
      nxt      = STEP_END;
      cur_last = 1'b0;
      case (cur)
         STEP_SYNC1: begin
            cur_byte = SYNC1_BYTE;
            nxt      = STEP_SYNC2;
         end
         STEP_SYNC2: begin
            cur_byte = SYNC2_BYTE;
            nxt      = STEP_LEN;
         end
         STEP_LEN: begin
            cur_byte = cmd.len_byte;
            nxt      = STEP_IDHI;
         end
         STEP_IDHI: begin
            cur_byte = cmd.id[15:8];
            nxt      = STEP_IDLO;
         end
         STEP_IDLO: begin
            cur_byte = cmd.id[7:0];
            nxt      = cmd.has_data ? STEP_DATA : STEP_CRCL;
         end
         STEP_DATA: begin
            cur_byte = cmd.data;
            nxt      = STEP_CRCL;
            cur_last = !cmd.trailer;
         end
         STEP_CRCL: begin
            cur_byte = crc_ff[7:0];
            nxt      = STEP_CRCH;
         end
         STEP_CRCH: begin
            cur_byte = crc_ff[15:8];
            nxt      = STEP_END;
         end
         STEP_END: begin
            cur_byte = END_BYTE;
            cur_last = 1'b1;
         end
         default: begin
            cur_byte = END_BYTE;
            cur_last = 1'b1;
         end
      endcase
   end

   assign cmd_pop = emit && cur_last;

   always_comb begin
      step_in    = step_ff;
      started_in = started_ff;
      crc_in     = crc_ff;
      valid_in   = valid_ff && !out_ready;
      if (emit) begin
         valid_in   = 1'b1;
         started_in = !cur_last;
         step_in    = nxt;
         if (cur == STEP_LEN) begin
            crc_in = crc16_byte('0, cur_byte);
         end else if (cur == STEP_IDHI || cur == STEP_IDLO || cur == STEP_DATA) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_SYNC1;
         started_ff <= 1'b0;
         crc_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         started_ff <= started_in;
         crc_ff     <= crc_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= cur_byte;
         end_ff  <= (cur == STEP_END);
         last_ff <= cur_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/crc16_frame_builder.sv =====
// Top level of the CRC-16 frame builder: front end, command queue and byte sequencer.
// Depends on cfb_pkg, cfb_if, cfb_front, cfb_queue and cfb_back.
//
// Use: req_ch carries payload items (frame_id, payload_length, data_byte);
// the item that opens a frame gives ID and length, each later item one payload
// byte. rsp_ch carries the framed byte stream, one byte per item, with
// frame_end on the AA end byte and run_last on the last byte an input item causes.
// An accepted item is written into the command queue; the sequencer reads it
// from there, and its bytes leave through the registered output item.
// The byte sequencer in cfb_back gives one output byte per cycle while a
// command is queued and the receiver is ready. A mid-frame item without trailer
// gives its data byte; an opening item gives sync, length and ID bytes and any
// data byte; the item that closes a frame adds the CRC bytes and the end byte.
// req_ch.ready is low only while the command queue is full.
// Reset clears frame position, CRC, queue and output valid.
// When the receiver stalls, the output item holds and the sequencer waits;
// items keep being accepted until the queue fills.
module crc16_frame_builder import cfb_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   cfb_req_if.sink  req_ch,
   cfb_rsp_if.source rsp_ch
);

   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_pop;
   cmd_type qb_cmd;

   cfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_id     (req_ch.frame_id),
      .in_len    (req_ch.payload_length),
      .in_data   (req_ch.data_byte),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   cfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop        (qb_pop),
      .pop_cmd    (qb_cmd)
   );

   cfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_pop   (qb_pop),
      .cmd       (qb_cmd),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_byte  (rsp_ch.out_byte),
      .out_end   (rsp_ch.frame_end),
      .out_last  (rsp_ch.run_last)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for crc16_frame_builder: random and directed payload items in,
// framed bytes checked against a frame/CRC-16 predictor. Uses rtl/cfb_pkg.sv,
// rtl/cfb_if.sv and rtl/crc16_frame_builder.sv.
module tb_top;
   import cfb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [ID_W-1:0]   frame_id;
      logic [BYTE_W-1:0] payload_length;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_end;
      logic              run_last;
   } rsp_item_type;

   logic clock;
   logic reset;

   cfb_req_if req_ch ();
   cfb_rsp_if rsp_ch ();

   crc16_frame_builder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_item_type tx_items[$];
   rsp_item_type frame_bytes_due[$];

   // predictor state
   logic              frame_open;
   logic [BYTE_W-1:0] pay_left;
   logic [ID_W-1:0]   crc_acc;

   // generator view of frame position
   int gen_left;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_cnt;
   int cycle_cnt;

   logic [7:0] hold_tok;
   logic [7:0] hold_seen;
   int         hold_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.frame_id = '0;
      req_ch.payload_length = '0;
      req_ch.data_byte = '0;
      rsp_ch.ready = 1'b0;
      hold_tok = '0;
      hold_seen = '0;
      hold_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [ID_W-1:0] crc_feed(logic [ID_W-1:0] c, logic [BYTE_W-1:0] b);
      logic fb;
      for (int i = BYTE_W-1; i >= 0; i--) begin
         fb = c[ID_W-1] ^ b[i];
         c = {c[ID_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   function void put_byte(logic [BYTE_W-1:0] b, logic fin);
      rsp_item_type r;
      r.out_byte = b;
      r.frame_end = fin;
      r.run_last = 1'b0;
      frame_bytes_due.push_back(r);
   endfunction

   function void put_crc(logic [BYTE_W-1:0] b);
      crc_acc = crc_feed(crc_acc, b);
      put_byte(b, 1'b0);
   endfunction

   function void put_trailer();
      put_byte(crc_acc[7:0], 1'b0);
      put_byte(crc_acc[15:8], 1'b0);
      put_byte(END_BYTE, 1'b1);
      frame_open = 1'b0;
      pay_left = '0;
   endfunction

   function void frame_predict(req_item_type it);
      logic [BYTE_W-1:0] plen;
      rsp_item_type      tail;
      if (!frame_open) begin
         plen = (it.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : it.payload_length;
         crc_acc = '0;
         put_byte(SYNC1_BYTE, 1'b0);
         put_byte(SYNC2_BYTE, 1'b0);
         put_crc(plen + LEN_OFFSET);
         put_crc(it.frame_id[15:8]);
         put_crc(it.frame_id[7:0]);
         if (plen == 0) begin
            put_trailer();
         end else begin
            put_crc(it.data_byte);
            pay_left = plen - 1'b1;
            if (pay_left == 0) begin
               put_trailer();
            end else begin
               frame_open = 1'b1;
            end
         end
      end else begin
         put_crc(it.data_byte);
         if (pay_left > 0) begin
            pay_left = pay_left - 1'b1;
         end
         if (pay_left == 0) begin
            put_trailer();
         end
      end
      tail = frame_bytes_due.pop_back();
      tail.run_last = 1'b1;
      frame_bytes_due.push_back(tail);
   endfunction

   function void add_item(logic [ID_W-1:0] id, logic [BYTE_W-1:0] len, logic [BYTE_W-1:0] d);
      req_item_type it;
      int           l;
      it.frame_id = id;
      it.payload_length = len;
      it.data_byte = d;
      tx_items.push_back(it);
      if (gen_left == 0) begin
         l = int'((len > MAX_PAYLOAD) ? MAX_PAYLOAD : len);
         gen_left = (l == 0) ? 0 : l - 1;
      end else begin
         gen_left--;
      end
   endfunction

   // mostly short frames, the odd longer one; optionally opens with an over-long length
   task automatic add_frames(int count, bit with_long);
      int n;
      int r;
      logic [BYTE_W-1:0] len;
      n = 0;
      while (n < count || gen_left != 0) begin
         if (gen_left == 0) begin
            r = $urandom_range(0, 99);
            if (with_long && n == 0) len = 8'hFF;
            else if (r < 15) len = 0;
            else if (r < 30) len = 1;
            else if (r < 85) len = BYTE_W'($urandom_range(2, 12));
            else len = BYTE_W'($urandom_range(13, 60));
         end else begin
            len = BYTE_W'($urandom);
         end
         add_item(ID_W'($urandom), len, BYTE_W'($urandom));
         n++;
      end
   endtask

   task automatic drain();
      while (tx_items.size() != 0 || req_ch.valid || frame_bytes_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic offering;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         offering = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            frame_predict(tx_items.pop_front());
            offering = 1'b0;
         end
         if (!offering) begin
            if (tx_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_ch.frame_id <= tx_items[0].frame_id;
               req_ch.payload_length <= tx_items[0].payload_length;
               req_ch.data_byte <= tx_items[0].data_byte;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_tok != hold_seen) begin
         hold_seen <= hold_tok;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected item: out_byte %h frame_end %b run_last %b",
                      rsp_ch.out_byte, rsp_ch.frame_end, rsp_ch.run_last);
               fail_cnt++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_ch.out_byte);
                  fail_cnt++;
               end
               if (rsp_ch.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end, rsp_ch.frame_end);
                  fail_cnt++;
               end
               if (rsp_ch.run_last !== want.run_last) begin
                  $error("run_last: expected %b, got %b", want.run_last, rsp_ch.run_last);
                  fail_cnt++;
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      cycle_cnt = 0;
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      frame_open = 1'b0;
      pay_left = '0;
      crc_acc = '0;
      gen_left = 0;
      fail_cnt = 0;
      send_idle_pct = 7;
      recv_idle_pct = 78;
      @(posedge clock);
      while (reset) @(posedge clock);

      // empty frames, data ignored
      add_item(16'h0000, 8'd0, 8'hFF);
      add_item(16'hFFFF, 8'd0, 8'h00);
      // single-byte payloads
      add_item(16'h1234, 8'd1, 8'h00);
      add_item(16'hFFFF, 8'd1, 8'hFF);
      // mid-frame ID and length ignored
      add_item(16'hA55A, 8'd3, 8'h80);
      add_item(16'hFFFF, 8'hFF, 8'h01);
      add_item(16'h0000, 8'h00, 8'hFE);
      add_item(16'h00FF, 8'd2, 8'hAA);
      add_item(16'hFF00, 8'h07, 8'h55);
      add_item(16'h8001, 8'd5, 8'h7F);
      add_item(16'hABCD, 8'hF8, 8'h10);
      add_item(16'h5555, 8'h01, 8'h20);
      add_item(16'hAAAA, 8'h00, 8'h40);
      add_item(16'h0F0F, 8'h80, 8'hC3);
      drain();

      // sender mostly busy, receiver mostly stalled, plus one long hold-off
      add_frames(170, 1'b0);
      hold_tok <= hold_tok + 1'b1;
      drain();

      send_idle_pct <= 78;
      recv_idle_pct <= 7;
      add_frames(170, 1'b0);
      drain();

      // no idling; opens with an over-long length, saturated to the maximum
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      add_frames(40, 1'b1);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_cnt == 0 && frame_bytes_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
